/* design/smf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types, widths and helpers for the sliding median filter.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int unsigned SampleW     = 16;
  localparam int unsigned CountW      = 5;
  localparam int unsigned HalfWindowD = 8;

  // one window entry as kept in the sorted chain
  typedef struct packed {
    logic                       valid;
    logic signed [SampleW-1:0]  value;
  } entry_t;

  // sort key: valid entries ascending by value, invalid entries last
  function automatic logic entry_lt(input entry_t a, input entry_t b);
    logic lt;
    if (!b.valid) begin
      lt = a.valid;
    end else begin
      lt = a.valid && (a.value < b.value);
    end
    return lt;
  endfunction

endpackage

/* design/smf_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_cell
// One slot of the sorted window: drops the oldest entry and inserts the new
// one by taking its own, its left or its right neighbor's entry, or the new.
// ----------------------------------------------------------------------------
module smf_cell #(
  parameter int unsigned Depth   = 17,
  parameter int unsigned CellIdx = 0,
  parameter int unsigned AgeW    = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  smf_pkg::entry_t     new_e_i,
  input  smf_pkg::entry_t     left_e_i,
  input  logic [AgeW-1:0]     left_age_i,
  input  logic                left_gt_i,
  input  logic                left_del_i,
  input  smf_pkg::entry_t     right_e_i,
  input  logic [AgeW-1:0]     right_age_i,
  input  logic                right_gt_i,
  output smf_pkg::entry_t     e_o,
  output logic [AgeW-1:0]     age_o,
  output logic                gt_o,
  output logic                del_o,
  output logic                del_valid_o
);

  smf_pkg::entry_t e_q, e_d;
  logic [AgeW-1:0] age_q, age_d;

  logic            gt_self, del_self;
  smf_pkg::entry_t cur_e, prv_e;
  logic [AgeW-1:0] cur_age, prv_age;
  logic            cur_gt, prv_gt;

  assign gt_self  = smf_pkg::entry_lt(new_e_i, e_q);
  assign del_self = (age_q == AgeW'(Depth - 1));

  // cur: this position after the oldest entry is removed, prv: the one before
  always_comb begin
    if (!del_o) begin
      cur_e   = e_q;
      cur_age = age_q;
      cur_gt  = gt_self;
    end else begin
      cur_e   = right_e_i;
      cur_age = right_age_i;
      cur_gt  = right_gt_i;
    end
    if (!left_del_i) begin
      prv_e   = left_e_i;
      prv_age = left_age_i;
      prv_gt  = left_gt_i;
    end else begin
      prv_e   = e_q;
      prv_age = age_q;
      prv_gt  = gt_self;
    end
  end

  always_comb begin
    if (!cur_gt) begin
      e_d   = cur_e;
      age_d = AgeW'(cur_age + 1'b1);
    end else if (!prv_gt) begin
      e_d   = new_e_i;
      age_d = '0;
    end else begin
      e_d   = prv_e;
      age_d = AgeW'(prv_age + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q   <= '0;
      age_q <= AgeW'(CellIdx);
    end else if (en_i) begin
      e_q   <= e_d;
      age_q <= age_d;
    end
  end

  assign e_o         = e_q;
  assign age_o       = age_q;
  assign gt_o        = gt_self;
  assign del_o       = left_del_i | del_self;
  assign del_valid_o = del_self & e_q.valid;

endmodule

/* design/smf_chain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_chain
// Row of sorted window cells with neighbor links and the evicted-entry flag.
// ----------------------------------------------------------------------------
module smf_chain #(
  parameter int unsigned Depth = 17,
  parameter int unsigned AgeW  = $clog2(Depth)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  smf_pkg::entry_t               new_e_i,
  output smf_pkg::entry_t [Depth-1:0]   entries_o,
  output logic                          del_valid_o
);

  smf_pkg::entry_t [Depth-1:0] e;
  logic [Depth-1:0][AgeW-1:0]  age;
  logic [Depth-1:0]            gt;
  logic [Depth-1:0]            del;
  logic [Depth-1:0]            del_valid;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    smf_pkg::entry_t left_e, right_e;
    logic [AgeW-1:0] left_age, right_age;
    logic            left_gt, left_del, right_gt;

    if (i == 0) begin : g_first
      assign left_e   = e[i];
      assign left_age = age[i];
      assign left_gt  = 1'b0;
      assign left_del = 1'b0;
    end else begin : g_mid_l
      assign left_e   = e[i-1];
      assign left_age = age[i-1];
      assign left_gt  = gt[i-1];
      assign left_del = del[i-1];
    end

    if (i == Depth - 1) begin : g_last
      // past the end sorts after everything
      assign right_e   = e[i];
      assign right_age = age[i];
      assign right_gt  = 1'b1;
    end else begin : g_mid_r
      assign right_e   = e[i+1];
      assign right_age = age[i+1];
      assign right_gt  = gt[i+1];
    end

    smf_cell #(
      .Depth   (Depth),
      .CellIdx (i),
      .AgeW    (AgeW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en_i),
      .new_e_i     (new_e_i),
      .left_e_i    (left_e),
      .left_age_i  (left_age),
      .left_gt_i   (left_gt),
      .left_del_i  (left_del),
      .right_e_i   (right_e),
      .right_age_i (right_age),
      .right_gt_i  (right_gt),
      .e_o         (e[i]),
      .age_o       (age[i]),
      .gt_o        (gt[i]),
      .del_o       (del[i]),
      .del_valid_o (del_valid[i])
    );
  end

  assign entries_o   = e;
  assign del_valid_o = |del_valid;

endmodule

/* design/sliding_median_with_flags.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_median_with_flags
// Pipeline: the cell row updates at the accept edge; the median is then picked
// from the row and registered into the output register once that is free.
// Throughput: one word per cycle; the cell row takes a new word whenever no
// result is pending or the pending result can move into the output register.
// Reset: the window is empty (all slots invalid), no result pending.
// ----------------------------------------------------------------------------
module sliding_median_with_flags #(
  parameter int unsigned HalfWindow = smf_pkg::HalfWindowD
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [smf_pkg::SampleW-1:0]    sample_i,
  input  logic                                  flagged_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [smf_pkg::SampleW-1:0]   median_o,
  output logic [smf_pkg::CountW-1:0]            valid_count_o,
  output logic                                  window_empty_o
);

  localparam int unsigned Depth  = 2 * HalfWindow + 1;
  localparam int unsigned AgeW   = $clog2(Depth);
  localparam int unsigned CntW   = $clog2(Depth + 1);

  smf_pkg::entry_t [Depth-1:0] entries;
  smf_pkg::entry_t             new_e;
  logic                        del_valid;
  logic                        accept, out_free;

  logic                        pend_q;
  logic [CntW-1:0]             count_q, count_d;
  logic [CntW-1:0]             half_cnt;
  logic [AgeW-1:0]             med_idx;

  logic                        out_valid_q;
  logic signed [smf_pkg::SampleW-1:0] median_q, median_d;
  logic [smf_pkg::CountW-1:0]  vcount_q;
  logic                        empty_q;

  assign new_e.valid = ~flagged_i;
  assign new_e.value = sample_i;

  assign out_free   = ~out_valid_q | out_ready_i;
  assign in_ready_o = ~pend_q | out_free;
  assign accept     = in_valid_i & in_ready_o;

  smf_chain #(
    .Depth (Depth),
    .AgeW  (AgeW)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (accept),
    .new_e_i     (new_e),
    .entries_o   (entries),
    .del_valid_o (del_valid)
  );

  // live count follows the evicted and the entering word
  assign count_d = CntW'(count_q - CntW'(del_valid) + CntW'(new_e.valid));

  assign half_cnt = count_q >> 1;
  assign med_idx  = half_cnt[AgeW-1:0];

  always_comb begin
    if (count_q == '0) begin
      median_d = '0;
    end else begin
      median_d = entries[med_idx].value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        pend_q <= 1'b1;
      end else if (out_free) begin
        pend_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= pend_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q && out_free) begin
      median_q <= median_d;
      vcount_q <= smf_pkg::CountW'(count_q);
      empty_q  <= (count_q == '0);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign median_o       = median_q;
  assign valid_count_o  = vcount_q;
  assign window_empty_o = empty_q;

endmodule
